// ----- design/utf16_to_utf8_transcoder_macros.svh -----
// Assertion macros shared by the checkers of the UTF-16 to UTF-8 transcoder.
// Plain text only; depends on nothing.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define U2U_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("transcoder check failed");

// Next-cycle implication, held off while reset is asserted.
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("transcoder check failed");

`endif

// ----- design/u16u8_pkg.sv -----
// Shared types, constants and the byte encoder of the UTF-16 to UTF-8 transcoder.
// Depends on nothing; the front end, queue, back end and top level import it.
package u16u8_pkg;

	localparam int CU_W = 16;
	localparam int CP_W = 21;
	localparam int BYTE_W = 8;

	localparam logic [CU_W-1:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [CU_W-1:0] HIGH_SURR_LAST = 16'hDBFF;
	localparam logic [CU_W-1:0] LOW_SURR_BASE = 16'hDC00;
	localparam logic [CU_W-1:0] LOW_SURR_LAST = 16'hDFFF;

	localparam logic [CP_W-1:0] ONE_BYTE_MAX = 21'h0007F;
	localparam logic [CP_W-1:0] TWO_BYTE_MAX = 21'h007FF;
	localparam logic [CP_W-1:0] THREE_BYTE_MAX = 21'h0FFFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// Encoded length, stored as byte count minus one.
	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} len_t;

	// One unit of work for the byte serialiser.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		len_t            len;
		logic            str_end;
	} desc_t;

	// Byte number idx of the UTF-8 encoding of cp.
	function automatic logic [BYTE_W-1:0] utf8_byte(logic [CP_W-1:0] cp, len_t len,
			logic [1:0] idx);
		logic [1:0]        rest;
		logic [BYTE_W-1:0] b;
		rest = 2'(len) - idx;
		if (idx == 2'd0) begin
			case (len)
				LEN_1: b = {1'b0, cp[6:0]};
				LEN_2: b = {3'b110, cp[10:6]};
				LEN_3: b = {4'b1110, cp[15:12]};
				default: b = {5'b11110, cp[20:18]};
			endcase
		end else begin
			case (rest)
				2'd0: b = {2'b10, cp[5:0]};
				2'd1: b = {2'b10, cp[11:6]};
				default: b = {2'b10, cp[17:12]};
			endcase
		end
		return b;
	endfunction

endpackage

// ----- design/u16u8_front.sv -----
// Front end: accepts code units, pairs surrogates and pushes one descriptor per code point.
// Depends on u16u8_pkg.
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [CU_W-1:0] s_tdata,
	output logic            push,
	output desc_t           push_data,
	input  logic            full
);

	logic            high_pending_q;
	logic [9:0]      high_bits_q;
	logic            accept;
	logic            is_zero;
	logic            is_high;
	logic            is_low;
	logic [CP_W-1:0] cp;

	assign s_tready = !full;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		is_zero = (s_tdata == '0);
		is_high = s_tdata inside {[HIGH_SURR_BASE:HIGH_SURR_LAST]};
		is_low = s_tdata inside {[LOW_SURR_BASE:LOW_SURR_LAST]};
		if (is_low && high_pending_q) begin
			cp = SUPP_BASE + {1'b0, high_bits_q, s_tdata[9:0]};
		end else begin
			cp = {{(CP_W-CU_W){1'b0}}, s_tdata};
		end
		push_data.cp = cp;
		push_data.str_end = is_zero;
		if (cp <= ONE_BYTE_MAX) begin
			push_data.len = LEN_1;
		end else if (cp <= TWO_BYTE_MAX) begin
			push_data.len = LEN_2;
		end else if (cp <= THREE_BYTE_MAX) begin
			push_data.len = LEN_3;
		end else begin
			push_data.len = LEN_4;
		end
		push = accept && !is_high;
	end

	// Hold a high surrogate; anything else drops it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			high_bits_q <= '0;
		end else if (accept) begin
			if (is_high) begin
				high_pending_q <= 1'b1;
				high_bits_q <= s_tdata[9:0];
			end else begin
				high_pending_q <= 1'b0;
				high_bits_q <= '0;
			end
		end
	end

endmodule

// ----- design/u16u8_fifo.sv -----
// Short descriptor queue between the front end and the byte serialiser.
// Depends on u16u8_pkg.
module u16u8_fifo
	import u16u8_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output desc_t pop_data,
	output logic  not_empty
);

	desc_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  count_q;
	logic                do_push;
	logic                do_pop;

	assign full = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/u16u8_back.sv -----
// Back end: takes descriptors from the queue and sends their UTF-8 bytes one a cycle while the output is not stalled.
// Depends on u16u8_pkg.
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              not_empty,
	input  desc_t             pop_data,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic              work_v_q;
	desc_t             work_q;
	logic [1:0]        idx_q;
	logic              out_v_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              end_q;
	logic              out_free;
	logic              emit;
	logic              last_byte;
	logic              work_take;

	assign out_free = !out_v_q || m_tready;
	assign emit = work_v_q && out_free;
	assign last_byte = (idx_q == 2'(work_q.len));
	assign work_take = !work_v_q || (emit && last_byte);
	assign pop = work_take && not_empty;

	assign m_tvalid = out_v_q;
	assign m_tdata = byte_q;
	assign m_tlast = last_q;
	assign m_tuser = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q <= 1'b0;
			idx_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (work_take) begin
				work_v_q <= not_empty;
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_free) begin
				out_v_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work_take) begin
			work_q <= pop_data;
		end
		if (emit) begin
			byte_q <= utf8_byte(work_q.cp, work_q.len, idx_q);
			last_q <= last_byte;
			end_q <= work_q.str_end;
		end
	end

endmodule

// ----- design/utf16_to_utf8_transcoder.sv -----
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back.

// Converts a stream of UTF-16 code units into UTF-8 bytes, one byte per output item.
// A high surrogate is held and produces nothing; a following low surrogate joins it into
// a supplementary code point sent as four bytes. Any other unit drops a held high
// surrogate and is encoded alone in one to three bytes (a lone low surrogate comes out
// as its own three-byte sequence). A zero unit sends a single 0x00 byte with both tlast
// and tuser high and clears the held surrogate. Rate: the output moves one byte per
// cycle while bytes are waiting and m_tready is high, set by the single byte serialiser
// in the back end; a code unit produces 0 to 4 bytes, 4 only for a surrogate pair. The input
// takes one unit per cycle while the four-entry descriptor queue has room, so short
// bursts of wide characters are absorbed without stalling the source. With an idle pipe
// the first byte of a unit passes through the queue entry, the serialiser's work register
// and its output register before it is presented on the output.
module utf16_to_utf8_transcoder
	import u16u8_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CU_W-1:0]   s_tdata,  // [15:0] code_unit
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,  // [7:0] out_byte
	output logic              m_tlast,  // unit_done: last byte for this code unit
	output logic              m_tuser   // [0] string_end
);

	// Descriptor path from the front end into the queue.
	logic  push;
	desc_t push_data;
	logic  full;

	// Descriptor path from the queue into the serialiser.
	logic  pop;
	desc_t pop_data;
	logic  not_empty;

	// Classify units, pair surrogates, stall the source only when the queue is full.
	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Decouple the two halves so each can stall on its own.
	u16u8_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	// Serialise each code point into bytes behind a registered output.
	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- design/u16u8_checker.sv -----
// Port-level checks on the output stream of the transcoder, bound to the top level.
// Depends on utf16_to_utf8_transcoder_macros.svh.
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// A stalled output item holds its place and contents.
	`U2U_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

	// The terminator is a lone zero byte that ends its unit.
	`U2U_ASSERT_SAME(a_end_byte, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00))

	// Any byte with more to follow is a lead or continuation byte.
	`U2U_ASSERT_SAME(a_mid_high, clk, arst_n, m_tvalid && !m_tlast, m_tdata[7])

	// A four-byte lead never closes its unit.
	`U2U_ASSERT_SAME(a_lead4_open, clk, arst_n, m_tvalid && (m_tdata[7:3] == 5'b11110), !m_tlast)

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
